[rtl/ghtc_pkg.sv]
package ghtc_pkg;

  // Field widths of one word on either side.
  localparam int REQ_W      = 2;
  localparam int ELAPSED_W  = 20;
  localparam int RATE_W     = 16;
  localparam int DIST_W     = 16;
  localparam int ANGLE_W    = 24;
  localparam int STEP_W     = 24;
  localparam int DATA_W     = 80;

  // Configuration register widths.
  localparam int INTERVAL_W = 20;
  localparam int GAIN_W     = 32;
  localparam int TOL_W      = 23;
  localparam int CFG_IDX_W  = 3;

  // Input word layout, lowest bit first.
  localparam int IN_ELAPSED_LSB = 0;
  localparam int IN_RATE_LSB    = IN_ELAPSED_LSB + ELAPSED_W;
  localparam int IN_IDLE_LSB    = IN_RATE_LSB + RATE_W;
  localparam int IN_DIST_LSB    = IN_IDLE_LSB + 1;
  localparam int IN_HVAL_LSB    = IN_DIST_LSB + DIST_W;

  // Serial multiplier geometry: a 37-bit multiplicand holds the rate times
  // accumulated time product, the 32-bit multiplier holds any gain.
  localparam int MC_W   = 37;
  localparam int MP_W   = 32;
  localparam int PROD_W = MC_W + MP_W;

  // Fixed-point scaling of each product.
  localparam int GYRO_SHIFT  = 32;
  localparam int TURN_SHIFT  = 16 + ANGLE_W;
  localparam int DRIVE_SHIFT = 16;

  // Configuration reset values.
  localparam logic [INTERVAL_W-1:0] IMU_INTERVAL_RST = 20'd0;
  localparam logic [GAIN_W-1:0]     GYRO_GAIN_RST    = 32'd1527099;
  localparam logic [GAIN_W-1:0]     TURN_GAIN_RST    = 32'd21845333;
  localparam logic [GAIN_W-1:0]     DRIVE_GAIN_RST   = 32'd69535;
  localparam logic [TOL_W-1:0]      TURN_TOL_RST     = 23'd1335;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_DRIVE  = 2'd1,
    MODE_DECIDE = 2'd2,
    MODE_TURN   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    REQ_TICK        = 2'd0,
    REQ_MOVE        = 2'd1,
    REQ_TURN_TO     = 2'd2,
    REQ_SET_HEADING = 2'd3
  } req_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMU_INTERVAL = 3'd0,
    CFG_GYRO_GAIN    = 3'd1,
    CFG_TURN_GAIN    = 3'd2,
    CFG_DRIVE_GAIN   = 3'd3,
    CFG_TURN_TOL     = 3'd4
  } cfg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE      = 3'd0,
    ST_DECODE    = 3'd1,
    ST_MUL_RATE  = 3'd2,
    ST_MUL_GYRO  = 3'd3,
    ST_MODE      = 3'd4,
    ST_MUL_TURN  = 3'd5,
    ST_MUL_DRIVE = 3'd6,
    ST_DONE      = 3'd7
  } seq_state_t;

  // Apply a sign to a step magnitude and clamp it to the signed step range.
  function automatic logic [STEP_W-1:0] sat_steps(input logic neg,
                                                  input logic [PROD_W-1:0] mag);
    logic             big;
    logic [STEP_W-1:0] m;
    big = |mag[PROD_W-1:STEP_W-1];
    m   = mag[STEP_W-1:0];
    if (big) begin
      sat_steps = neg ? {1'b1, {(STEP_W-1){1'b0}}} : {1'b0, {(STEP_W-1){1'b1}}};
    end else begin
      sat_steps = neg ? (~m + 1'b1) : m;
    end
  endfunction

endpackage

[rtl/ghtc_serial_mul.sv]
module ghtc_serial_mul #(
  parameter int MC_W = 37,
  parameter int MP_W = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [MC_W-1:0]      mcand,
  input  logic [MP_W-1:0]      mplier,
  output logic                 done,
  output logic [MC_W+MP_W-1:0] product
);

  localparam int CNT_W = $clog2(MP_W + 1);

  logic [CNT_W-1:0] cnt;
  logic [MC_W-1:0]  acc;
  logic [MC_W-1:0]  mcand_q;
  logic [MP_W-1:0]  low;
  logic [MC_W:0]    sum;

  // One multiplier bit per cycle: add the multiplicand when the bit is set.
  assign sum = {1'b0, acc} + (low[0] ? {1'b0, mcand_q} : {(MC_W+1){1'b0}});

  // Iteration counter and completion pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= CNT_W'(MP_W);
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  // Shift-add datapath; the multiplier register fills with low product bits.
  always_ff @(posedge clk) begin
    if (start) begin
      acc     <= '0;
      low     <= mplier;
      mcand_q <= mcand;
    end else if (cnt != '0) begin
      {acc, low} <= {sum, low[MP_W-1:1]};
    end
  end

  assign product = {acc, low};

endmodule

[rtl/gyro_heading_turn_controller_unit.sv]
// Requests take different paths: set or turn to heading go straight to the output,
// a tick without integration passes through the mode step, a straight move uses one
// multiplier pass, and a tick that integrates and then decides a turn uses three
// passes of one bit-serial 37x32 multiplier. One word is in work at a time; the next
// is taken the cycle after its result enters the output register. Synchronous rst restores
// the gains, clears heading, target, mode and time, and empties the output.
module gyro_heading_turn_controller_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // elapsed_us, gyro_rate, motors_idle, distance_mm, heading_value, zero pad
  input  logic [ghtc_pkg::DATA_W-1:0]       s_tdata,
  // req_type
  input  logic [ghtc_pkg::REQ_W-1:0]        s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // mode, heading, move_valid, left_steps, right_steps, run_motors,
  // stop_motion, zero pad
  output logic [ghtc_pkg::DATA_W-1:0]       m_tdata,
  input  logic                              cfg_wr_en,
  input  logic [ghtc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ghtc_pkg::GAIN_W-1:0]       cfg_data
);

  import ghtc_pkg::*;

  // Configuration.
  logic [INTERVAL_W-1:0] imu_interval;
  logic [GAIN_W-1:0]     gyro_gain;
  logic [GAIN_W-1:0]     turn_gain;
  logic [GAIN_W-1:0]     drive_gain;
  logic [TOL_W-1:0]      turn_tol;

  // Controller state.
  seq_state_t           state, state_next;
  logic [ANGLE_W-1:0]   heading_angle;
  logic [ANGLE_W-1:0]   target_angle;
  mode_t                control_mode;
  logic [INTERVAL_W-1:0] tss;

  // Captured input word.
  req_t                 req_q;
  logic [ELAPSED_W-1:0] elapsed_q;
  logic [RATE_W-1:0]    rate_q;
  logic                 idle_q;
  logic [DIST_W-1:0]    dist_q;
  logic [ANGLE_W-1:0]   hval_q;

  // Result fields under construction.
  logic                 mv_q;
  logic [STEP_W-1:0]    ls_q;
  logic [STEP_W-1:0]    rs_q;
  logic                 run_q;
  logic                 stop_q;

  // Multiplier connection.
  logic                 mul_start;
  logic [MC_W-1:0]      mul_mcand;
  logic [MP_W-1:0]      mul_mplier;
  logic                 mul_done;
  logic [PROD_W-1:0]    mul_product;

  // Datapath helpers.
  logic [INTERVAL_W:0]  tss_sum;
  logic                 sample_due;
  logic                 rate_neg;
  logic [RATE_W:0]      rate_ext;
  logic [RATE_W:0]      rate_mag;
  logic                 dist_neg;
  logic [DIST_W:0]      dist_ext;
  logic [DIST_W:0]      dist_mag;
  logic [ANGLE_W-1:0]   err;
  logic                 err_neg;
  logic [ANGLE_W-1:0]   err_mag;
  logic                 within_tol;
  logic [ANGLE_W-1:0]   gyro_q;
  logic                 gyro_sticky;
  logic [ANGLE_W-1:0]   gyro_up;
  logic [ANGLE_W-1:0]   heading_delta;
  logic [PROD_W-1:0]    turn_s;
  logic [PROD_W-1:0]    drive_s;
  logic                 out_free;

  ghtc_serial_mul #(
    .MC_W (MC_W),
    .MP_W (MP_W)
  ) u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .mcand   (mul_mcand),
    .mplier  (mul_mplier),
    .done    (mul_done),
    .product (mul_product)
  );

  // Time accumulation and sample decision.
  assign tss_sum    = {1'b0, tss} + {1'b0, elapsed_q};
  assign sample_due = tss_sum > {1'b0, imu_interval};

  // Sign and magnitude of the signed inputs.
  assign rate_neg = rate_q[RATE_W-1];
  assign rate_ext = {rate_q[RATE_W-1], rate_q};
  assign rate_mag = rate_neg ? (~rate_ext + 1'b1) : rate_ext;
  assign dist_neg = dist_q[DIST_W-1];
  assign dist_ext = {dist_q[DIST_W-1], dist_q};
  assign dist_mag = dist_neg ? (~dist_ext + 1'b1) : dist_ext;

  // Wrapped heading error; half a turn lands on the negative end.
  assign err        = target_angle - heading_angle;
  assign err_neg    = err[ANGLE_W-1];
  assign err_mag    = err_neg ? (~err + 1'b1) : err;
  assign within_tol = err_mag < {1'b0, turn_tol};

  // Heading increment, floored toward minus infinity for negative rates.
  assign gyro_q        = mul_product[GYRO_SHIFT +: ANGLE_W];
  assign gyro_sticky   = |mul_product[GYRO_SHIFT-1:0];
  assign gyro_up       = gyro_q + {{(ANGLE_W-1){1'b0}}, gyro_sticky};
  assign heading_delta = rate_neg ? (~gyro_up + 1'b1) : gyro_q;

  assign turn_s  = mul_product >> TURN_SHIFT;
  assign drive_s = mul_product >> DRIVE_SHIFT;

  assign out_free = !m_tvalid || m_tready;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      imu_interval <= IMU_INTERVAL_RST;
      gyro_gain    <= GYRO_GAIN_RST;
      turn_gain    <= TURN_GAIN_RST;
      drive_gain   <= DRIVE_GAIN_RST;
      turn_tol     <= TURN_TOL_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index_t'(cfg_index))
        CFG_IMU_INTERVAL: imu_interval <= cfg_data[INTERVAL_W-1:0];
        CFG_GYRO_GAIN:    gyro_gain    <= cfg_data;
        CFG_TURN_GAIN:    turn_gain    <= cfg_data;
        CFG_DRIVE_GAIN:   drive_gain   <= cfg_data;
        CFG_TURN_TOL:     turn_tol     <= cfg_data[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer next state, input handshake and multiplier launches.
  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    mul_start  = 1'b0;
    mul_mcand  = '0;
    mul_mplier = '0;
    case (state)
      ST_IDLE: begin
        s_tready = !rst;
        if (s_tvalid) begin
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (req_q)
          REQ_TICK: begin
            if (sample_due) begin
              mul_start  = 1'b1;
              mul_mcand  = MC_W'(tss_sum);
              mul_mplier = MP_W'(rate_mag);
              state_next = ST_MUL_RATE;
            end else begin
              state_next = ST_MODE;
            end
          end
          REQ_MOVE: begin
            mul_start  = 1'b1;
            mul_mcand  = MC_W'(dist_mag);
            mul_mplier = drive_gain;
            state_next = ST_MUL_DRIVE;
          end
          default: state_next = ST_DONE;
        endcase
      end
      ST_MUL_RATE: begin
        if (mul_done) begin
          mul_start  = 1'b1;
          mul_mcand  = mul_product[MC_W-1:0];
          mul_mplier = gyro_gain;
          state_next = ST_MUL_GYRO;
        end
      end
      ST_MUL_GYRO: begin
        if (mul_done) begin
          state_next = ST_MODE;
        end
      end
      ST_MODE: begin
        if (control_mode == MODE_DECIDE && !within_tol) begin
          mul_start  = 1'b1;
          mul_mcand  = MC_W'(err_mag);
          mul_mplier = turn_gain;
          state_next = ST_MUL_TURN;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_MUL_TURN, ST_MUL_DRIVE: begin
        if (mul_done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Heading, target, mode and time accumulator updates.
  always_ff @(posedge clk) begin
    if (rst) begin
      heading_angle <= '0;
      target_angle  <= '0;
      control_mode  <= MODE_IDLE;
      tss           <= '0;
    end else begin
      case (state)
        ST_DECODE: begin
          case (req_q)
            REQ_TICK: begin
              if (!sample_due) begin
                tss <= tss_sum[INTERVAL_W-1:0];
              end
            end
            REQ_MOVE: control_mode <= MODE_DRIVE;
            REQ_TURN_TO: begin
              target_angle <= hval_q;
              control_mode <= MODE_DECIDE;
            end
            REQ_SET_HEADING: begin
              heading_angle <= hval_q;
              target_angle  <= hval_q;
              control_mode  <= MODE_IDLE;
              tss           <= '0;
            end
            default: ;
          endcase
        end
        ST_MUL_GYRO: begin
          if (mul_done) begin
            heading_angle <= heading_angle + heading_delta;
            tss           <= '0;
          end
        end
        ST_MODE: begin
          case (control_mode)
            MODE_DRIVE: begin
              if (idle_q) begin
                control_mode <= MODE_IDLE;
              end
            end
            MODE_TURN: begin
              if (idle_q) begin
                control_mode <= MODE_DECIDE;
              end
            end
            MODE_DECIDE: begin
              if (within_tol) begin
                control_mode <= MODE_IDLE;
              end
            end
            default: ;
          endcase
        end
        ST_MUL_TURN: begin
          if (mul_done) begin
            control_mode <= MODE_TURN;
          end
        end
        default: ;
      endcase
    end
  end

  // Input capture and result fields.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          req_q     <= req_t'(s_tuser);
          elapsed_q <= s_tdata[IN_ELAPSED_LSB +: ELAPSED_W];
          rate_q    <= s_tdata[IN_RATE_LSB +: RATE_W];
          idle_q    <= s_tdata[IN_IDLE_LSB];
          dist_q    <= s_tdata[IN_DIST_LSB +: DIST_W];
          hval_q    <= s_tdata[IN_HVAL_LSB +: ANGLE_W];
          mv_q      <= 1'b0;
          ls_q      <= '0;
          rs_q      <= '0;
          run_q     <= 1'b0;
          stop_q    <= 1'b0;
        end
      end
      ST_MODE: begin
        if (control_mode == MODE_DRIVE || control_mode == MODE_TURN) begin
          run_q <= 1'b1;
        end
        if (control_mode == MODE_DECIDE && within_tol) begin
          stop_q <= 1'b1;
        end
      end
      ST_MUL_TURN: begin
        if (mul_done) begin
          mv_q <= 1'b1;
          ls_q <= sat_steps(!err_neg, turn_s);
          rs_q <= sat_steps(err_neg, turn_s);
        end
      end
      ST_MUL_DRIVE: begin
        if (mul_done) begin
          mv_q <= 1'b1;
          ls_q <= sat_steps(dist_neg, drive_s);
          rs_q <= sat_steps(dist_neg, drive_s);
        end
      end
      default: ;
    endcase
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Output word, packed from the lowest field up.
  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      m_tdata <= DATA_W'({stop_q, run_q, rs_q, ls_q, mv_q, heading_angle,
                          control_mode});
    end
  end

endmodule
